[hdl/g2l_pkg.sv]
`default_nettype none

package g2l_pkg;

  // Table geometry
  localparam int FIRST_YEAR  = 2000;
  localparam int TABLE_YEARS = 50;
  localparam int TBL_DEPTH   = 50;
  localparam int TIDX_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int YEAR_BIAS   = 2000 - FIRST_YEAR;

  // One walk stage per possible month step, plus the front and finish stages
  localparam int WALK_STEPS = 12;
  localparam int PIPE_LAT   = WALK_STEPS + 2;

  // Month index bounds of the walk
  localparam logic [3:0] IDX_FIRST = 4'd1;
  localparam logic [3:0] IDX_LAST  = 4'd13;
  localparam logic [3:0] MON_LAST  = 4'd12;

  // Month lengths and festival month code
  localparam logic [4:0] LEN_SHORT  = 5'd29;
  localparam logic [4:0] LEN_LONG   = 5'd30;
  localparam logic [1:0] SPRING_JAN = 2'd1;

  // Year offset of 2100, a century year that is not leap
  localparam logic [6:0] YOFF_2100 = 7'd100;

  // Per-year word: leap month, month lengths, festival month and day
  localparam logic [23:0] LUNAR_WORDS [TBL_DEPTH] = '{
    24'h0C9645, 24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49, 24'h7AADBD,
    24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E, 24'h0B4A43, 24'h4B5537, 24'h0AD54A,
    24'h955ABF, 24'h04BA53, 24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
    24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D, 24'h0A4E51, 24'h0D2646,
    24'h5E933A, 24'h0D534D, 24'h05AA43, 24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53,
    24'h0A4D48, 24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C, 24'h056D41,
    24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51, 24'h0AA546, 24'h5B52BA, 24'h06D24E,
    24'h0ADA42
  };

  localparam logic [8:0] DAYS_BEFORE [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // State carried down the month walk
  typedef struct packed {
    logic        ok;       // month valid and all needed table words exist
    logic        fwd;      // walking forward from the festival
    logic [23:0] word;     // table word of the lunar year walked
    logic [8:0]  rem;      // days still to place
    logic [3:0]  mon_idx;  // month index 1..13
    logic [3:0]  lm;       // lunar month number
    logic        flag;     // inside the leap month
    logic [6:0]  ly;       // lunar year offset
  } walk_t;

  // Length of month index i in word w
  function automatic logic [4:0] month_len(logic [23:0] w, logic [3:0] i);
    logic [4:0] bitpos;
    bitpos = 5'd20 - {1'b0, i};
    if (i < IDX_FIRST || i > IDX_LAST) return LEN_SHORT;
    return w[bitpos] ? LEN_LONG : LEN_SHORT;
  endfunction

endpackage

`default_nettype wire

[hdl/g2l_front.sv]
`default_nettype none

module g2l_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [6:0]        yoff,
  input  wire logic [3:0]        month,
  input  wire logic [4:0]        day,
  output logic                   vld_r,
  output g2l_pkg::walk_t         walk_r
);

  logic signed [9:0] tidx, pidx, sun, spring;
  logic              cur_ok, prv_ok, mon_ok, leap_yr, fwd;
  logic [23:0]       cur_w, prv_w;
  logic [8:0]        dbm;
  logic [3:0]        pleap;
  g2l_pkg::walk_t    walk_nxt;

  // Table indexes for this year and the one before
  assign tidx = $signed({3'b000, yoff}) + $signed(10'(g2l_pkg::YEAR_BIAS));
  assign pidx = tidx - 10'sd1;

  assign cur_ok = (tidx >= 10'sd0) && (tidx < $signed(10'(g2l_pkg::TABLE_YEARS)))
               && (tidx < $signed(10'(g2l_pkg::TBL_DEPTH)));
  assign prv_ok = (pidx >= 10'sd0) && (pidx < $signed(10'(g2l_pkg::TABLE_YEARS)))
               && (pidx < $signed(10'(g2l_pkg::TBL_DEPTH)));

  assign cur_w = cur_ok ? g2l_pkg::LUNAR_WORDS[tidx[g2l_pkg::TIDX_W-1:0]] : '0;
  assign prv_w = prv_ok ? g2l_pkg::LUNAR_WORDS[pidx[g2l_pkg::TIDX_W-1:0]] : '0;

  // Day of year, zero based; Feb 29 counts in Gregorian leap years
  assign mon_ok  = (month >= 4'd1) && (month <= g2l_pkg::MON_LAST);
  assign dbm     = mon_ok ? g2l_pkg::DAYS_BEFORE[4'(month - 4'd1)] : '0;
  // 2000 is leap (divisible by 400), 2100 is not
  assign leap_yr = (yoff[1:0] == 2'b00) && (yoff != g2l_pkg::YOFF_2100);
  assign sun     = $signed({1'b0, dbm}) + $signed({5'b00000, day}) - 10'sd1
                 + $signed({9'b0, leap_yr && (month > 4'd2)});

  // Festival day of year, zero based
  assign spring = (cur_w[6:5] == g2l_pkg::SPRING_JAN)
                ? $signed({5'b00000, cur_w[4:0]}) - 10'sd1
                : $signed({5'b00000, cur_w[4:0]}) + 10'sd30;

  assign fwd   = (sun >= spring);
  assign pleap = prv_w[23:20];

  // Initial walk state
  always_comb begin
    walk_nxt.ok   = mon_ok && cur_ok && (fwd || prv_ok);
    walk_nxt.fwd  = fwd;
    walk_nxt.flag = 1'b0;
    if (fwd) begin
      walk_nxt.word    = cur_w;
      walk_nxt.rem     = 9'(sun - spring);
      walk_nxt.mon_idx = g2l_pkg::IDX_FIRST;
      walk_nxt.lm      = 4'd1;
      walk_nxt.ly      = yoff;
    end else begin
      walk_nxt.word    = prv_w;
      walk_nxt.rem     = 9'(spring - sun);
      walk_nxt.mon_idx = (pleap == 4'd0) ? g2l_pkg::MON_LAST : g2l_pkg::IDX_LAST;
      walk_nxt.lm      = g2l_pkg::MON_LAST;
      walk_nxt.ly      = yoff - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
  end

endmodule

`default_nettype wire

[hdl/g2l_step.sv]
`default_nettype none

module g2l_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld_i,
  input  wire g2l_pkg::walk_t    walk_i,
  output logic                   vld_r,
  output g2l_pkg::walk_t         walk_r
);

  logic [4:0]     len;
  logic [3:0]     leap, lm_dec;
  logic           adv, flag_fwd;
  g2l_pkg::walk_t walk_nxt;

  assign len    = g2l_pkg::month_len(walk_i.word, walk_i.mon_idx);
  assign leap   = walk_i.word[23:20];
  assign lm_dec = walk_i.flag ? walk_i.lm : walk_i.lm - 4'd1;

  // Step past the current month while the remaining days overrun it
  assign adv = walk_i.fwd
             ? ((walk_i.rem >= {4'b0000, len}) && (walk_i.mon_idx < g2l_pkg::IDX_LAST))
             : ((walk_i.rem >  {4'b0000, len}) && (walk_i.mon_idx > g2l_pkg::IDX_FIRST));

  assign flag_fwd = !walk_i.flag;

  always_comb begin
    walk_nxt = walk_i;
    if (adv) begin
      walk_nxt.rem = walk_i.rem - {4'b0000, len};
      if (walk_i.fwd) begin
        walk_nxt.mon_idx = walk_i.mon_idx + 4'd1;
        // leap month repeats the number: count up only when leaving it
        if (walk_i.lm == leap) begin
          walk_nxt.flag = flag_fwd;
          walk_nxt.lm   = flag_fwd ? walk_i.lm : walk_i.lm + 4'd1;
        end else begin
          walk_nxt.lm   = walk_i.lm + 4'd1;
        end
      end else begin
        walk_nxt.mon_idx = walk_i.mon_idx - 4'd1;
        walk_nxt.lm      = lm_dec;
        if (lm_dec == leap) begin
          walk_nxt.flag = !walk_i.flag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
  end

endmodule

`default_nettype wire

[hdl/g2l_finish.sv]
`default_nettype none

module g2l_finish (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld_i,
  input  wire g2l_pkg::walk_t    walk_i,
  output logic                   out_vld_r,
  output logic [6:0]             year_r,
  output logic [3:0]             month_r,
  output logic [4:0]             day_r,
  output logic                   ok_r
);

  logic [4:0] len, ld;

  // Day within the month the walk stopped on
  assign len = g2l_pkg::month_len(walk_i.word, walk_i.mon_idx);
  assign ld  = walk_i.fwd ? walk_i.rem[4:0] + 5'd1
                          : len - walk_i.rem[4:0] + 5'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_i;
    end
  end

  // Out-of-range items report all zeros
  always_ff @(posedge clk) begin
    ok_r    <= walk_i.ok;
    year_r  <= walk_i.ok ? walk_i.ly : 7'd0;
    month_r <= walk_i.ok ? walk_i.lm : 4'd0;
    day_r   <= walk_i.ok ? ld : 5'd0;
  end

endmodule

`default_nettype wire

[hdl/gregorian_to_lunar_date.sv]
// A result strobes on out_valid once its transaction has passed the front, walk and finish registers.
// Throughput: one transaction per cycle; busy stays low outside reset.
// The twelve month-walk stages, one lunar month step each, set the pipeline depth.
// Reset: synchronous, active low; clears all stage valid bits, holds busy high
// during reset, and busy drops the cycle after rst_n rises. The receiver cannot stall.
`default_nettype none

module gregorian_to_lunar_date (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [6:0]  in_year_offset,
  input  wire logic [3:0]  in_month,
  input  wire logic [4:0]  in_day,
  output logic             out_valid,
  output logic [6:0]       out_lunar_year,
  output logic [3:0]       out_lunar_month,
  output logic [4:0]       out_lunar_day,
  output logic             out_in_range
);

  logic                          busy_r;
  logic [g2l_pkg::WALK_STEPS:0]  vld;
  g2l_pkg::walk_t                walk [g2l_pkg::WALK_STEPS+1];

  // Busy only while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Festival offset and walk setup
  g2l_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start && !busy_r),
    .yoff   (in_year_offset),
    .month  (in_month),
    .day    (in_day),
    .vld_r  (vld[0]),
    .walk_r (walk[0])
  );

  // Month walk, one step per stage
  for (genvar s = 0; s < g2l_pkg::WALK_STEPS; s++) begin : g_walk
    g2l_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld[s]),
      .walk_i (walk[s]),
      .vld_r  (vld[s+1]),
      .walk_r (walk[s+1])
    );
  end

  // Lunar day and output register
  g2l_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (vld[g2l_pkg::WALK_STEPS]),
    .walk_i    (walk[g2l_pkg::WALK_STEPS]),
    .out_vld_r (out_valid),
    .year_r    (out_lunar_year),
    .month_r   (out_lunar_month),
    .day_r     (out_lunar_day),
    .ok_r      (out_in_range)
  );

  // Every result traces back to a transaction accepted at the front of the pipeline
  a_res_has_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, g2l_pkg::PIPE_LAT))
    else $error("result without accepted transaction");

  // Out-of-range results carry zero fields
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |->
      (out_lunar_year == 7'd0 && out_lunar_month == 4'd0 && out_lunar_day == 5'd0))
    else $error("out-of-range result not zeroed");

  // A bad Gregorian month never yields an in-range result
  a_bad_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_month, g2l_pkg::PIPE_LAT) == 4'd0
                || $past(in_month, g2l_pkg::PIPE_LAT) > g2l_pkg::MON_LAST)) |->
      !out_in_range)
    else $error("invalid month reported in range");

  // Lunar year is the Gregorian year or the one before
  a_year_track: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_range) |->
      (out_lunar_year == $past(in_year_offset, g2l_pkg::PIPE_LAT)
    || out_lunar_year == 7'($past(in_year_offset, g2l_pkg::PIPE_LAT) - 7'd1)))
    else $error("lunar year does not track input year");

endmodule

`default_nettype wire
